### design/shock_peak_monitor_macros.svh
// ----------------------------------------------------------------------------
// shock peak monitor assertion macros
// concurrent check wrappers shared by the shock peak monitor rtl
// ----------------------------------------------------------------------------
`ifndef SHOCK_PEAK_MONITOR_MACROS_SVH
`define SHOCK_PEAK_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define SPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spm check failed");

// next-cycle implication, disabled in reset
`define SPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spm check failed");

`else

`define SPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// types and constants of the shock peak monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spm_pkg;

    // input beat: one three-axis sample
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    // output beat: one shock event or one periodic report
    typedef struct packed {
        logic        kind;
        logic [15:0] g_level;
        logic [1:0]  status;
        logic        last;
    } out_t;

    // configuration register set
    typedef struct packed {
        logic [15:0] shock_threshold;
        logic [15:0] dead_time_samples;
        logic [15:0] report_period_samples;
        logic [15:0] motion_high;
        logic [15:0] motion_low;
    } cfg_t;

    // register indexes
    localparam logic [2:0] REG_SHOCK_THR   = 3'd0;
    localparam logic [2:0] REG_DEAD_TIME   = 3'd1;
    localparam logic [2:0] REG_REPORT_PER  = 3'd2;
    localparam logic [2:0] REG_MOTION_HIGH = 3'd3;
    localparam logic [2:0] REG_MOTION_LOW  = 3'd4;

    // register reset values
    localparam logic [15:0] RST_SHOCK_THR   = 16'd7373;
    localparam logic [15:0] RST_DEAD_TIME   = 16'd150;
    localparam logic [15:0] RST_REPORT_PER  = 16'd3000;
    localparam logic [15:0] RST_MOTION_HIGH = 16'd5325;
    localparam logic [15:0] RST_MOTION_LOW  = 16'd2867;

    // one g in raw counts, and the saturation level of the sample counters
    localparam logic [15:0] ONE_G = 16'd4096;
    localparam logic [15:0] SAT16 = 16'hFFFF;

    // result kinds
    localparam logic KIND_SHOCK  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // report classes
    localparam logic [1:0] ST_SAFE   = 2'd0;
    localparam logic [1:0] ST_MOVING = 2'd1;
    localparam logic [1:0] ST_STRONG = 2'd2;

endpackage

### design/shock_peak_monitor.sv
// ----------------------------------------------------------------------------
// shock_peak_monitor
// accelerometer shock detector with peak hold and periodic class reports
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid / in_stall / in_data) takes one x, y, z sample per beat.
//   out channel (out_valid / out_stall / out_data) gives zero, one or two beats
//   per sample: a shock event first, then a periodic report; last marks the
//   final beat of a sample.
//   the magnitude is floor(sqrt(x*x + y*y + z*z)): the squares are summed on the
//   shared squarer, then the root unit works it out one bit per step.
//   in_stall stays high while a sample is in work, so a new sample is taken
//   only once the previous one has finished.
//   results sit in an output register plus one extra slot; a sample that is
//   ready to finish waits while either holds a beat, so a stalled receiver
//   holds back the next sample and nothing is dropped.
//   reset: registers return to defaults, peak is one g, the dead time starts
//   already expired and the report count is zero.
//   configuration is written over apb at byte address 4 * index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shock_peak_monitor_macros.svh"

module shock_peak_monitor
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  spm_pkg::in_t      in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output spm_pkg::out_t     out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAG  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    spm_pkg::cfg_t cfg;
    logic          mag_done;
    logic [15:0]   mag;

    logic [1:0]    state_reg;
    logic [15:0]   peak_reg;
    logic [15:0]   since_reg;
    logic [15:0]   count_reg;
    logic          out_valid_reg;
    spm_pkg::out_t out_reg;
    logic          pend_valid_reg;
    spm_pkg::out_t pend_reg;

    logic          in_acc;
    logic          out_take;
    logic          fin;
    logic [15:0]   since_next;
    logic [15:0]   count_next;
    logic [15:0]   peak_max;
    logic [15:0]   peak_shock;
    logic [15:0]   peak_next;
    logic          shock;
    logic          report;
    logic [1:0]    cls;
    spm_pkg::out_t shock_beat;
    spm_pkg::out_t report_beat;

    spm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spm_mag u_mag
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_acc),
        .sample (in_data),
        .done   (mag_done),
        .mag    (mag)
    );

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign fin       = (state_reg == S_FIN) && !out_valid_reg && !pend_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // per-sample decision: counters, peak hold, shock and report
    always_comb
    begin
        since_next = (since_reg == spm_pkg::SAT16) ? since_reg : since_reg + 16'd1;
        count_next = (count_reg == spm_pkg::SAT16) ? count_reg : count_reg + 16'd1;
        peak_max   = (mag > peak_reg) ? mag : peak_reg;
        shock      = (mag >= cfg.shock_threshold) && (since_next >= cfg.dead_time_samples);
        peak_shock = shock ? spm_pkg::ONE_G : peak_max;
        report     = (count_next >= cfg.report_period_samples);
        peak_next  = report ? spm_pkg::ONE_G : peak_shock;

        if (peak_shock > cfg.shock_threshold)
            cls = spm_pkg::ST_STRONG;
        else if ((peak_shock > cfg.motion_high) || (peak_shock < cfg.motion_low))
            cls = spm_pkg::ST_MOVING;
        else
            cls = spm_pkg::ST_SAFE;

        shock_beat.kind     = spm_pkg::KIND_SHOCK;
        shock_beat.g_level  = mag;
        shock_beat.status   = spm_pkg::ST_STRONG;
        shock_beat.last     = !report;
        report_beat.kind    = spm_pkg::KIND_REPORT;
        report_beat.g_level = peak_shock;
        report_beat.status  = cls;
        report_beat.last    = 1'b1;
    end

    // sequencer and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            peak_reg  <= spm_pkg::ONE_G;
            since_reg <= spm_pkg::SAT16;
            count_reg <= 16'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                        state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    if (mag_done)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin)
                    begin
                        state_reg <= S_IDLE;
                        peak_reg  <= peak_next;
                        since_reg <= shock ? 16'd0 : since_next;
                        count_reg <= report ? 16'd0 : count_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register and extra slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (fin)
        begin
            out_valid_reg  <= shock || report;
            pend_valid_reg <= shock && report;
        end
        else if (out_take)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    // output payloads
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            out_reg  <= shock ? shock_beat : report_beat;
            pend_reg <= report_beat;
        end
        else if (out_take && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    `SPM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall)
    `SPM_ASSERT_IMP(a_pend_needs_out, clk, rst_n, pend_valid_reg, out_valid_reg)
    `SPM_ASSERT_IMP(a_pend_behind_shock, clk, rst_n, pend_valid_reg,
        (out_reg.kind == spm_pkg::KIND_SHOCK) && !out_reg.last)
    `SPM_ASSERT_IMP(a_done_in_mag, clk, rst_n, mag_done, state_reg == S_MAG)

endmodule

### design/spm_regs.sv
// ----------------------------------------------------------------------------
// spm_regs
// apb configuration registers of the shock peak monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output spm_pkg::cfg_t     cfg
);

    spm_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;
    logic [15:0]   rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // register write, out-of-range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shock_threshold       <= spm_pkg::RST_SHOCK_THR;
            cfg_reg.dead_time_samples     <= spm_pkg::RST_DEAD_TIME;
            cfg_reg.report_period_samples <= spm_pkg::RST_REPORT_PER;
            cfg_reg.motion_high           <= spm_pkg::RST_MOTION_HIGH;
            cfg_reg.motion_low            <= spm_pkg::RST_MOTION_LOW;
        end
        else if (wr_en)
        begin
            unique case (idx)
                spm_pkg::REG_SHOCK_THR:   cfg_reg.shock_threshold       <= pwdata[15:0];
                spm_pkg::REG_DEAD_TIME:   cfg_reg.dead_time_samples     <= pwdata[15:0];
                spm_pkg::REG_REPORT_PER:  cfg_reg.report_period_samples <= pwdata[15:0];
                spm_pkg::REG_MOTION_HIGH: cfg_reg.motion_high           <= pwdata[15:0];
                spm_pkg::REG_MOTION_LOW:  cfg_reg.motion_low            <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            spm_pkg::REG_SHOCK_THR:   rd_val = cfg_reg.shock_threshold;
            spm_pkg::REG_DEAD_TIME:   rd_val = cfg_reg.dead_time_samples;
            spm_pkg::REG_REPORT_PER:  rd_val = cfg_reg.report_period_samples;
            spm_pkg::REG_MOTION_HIGH: rd_val = cfg_reg.motion_high;
            spm_pkg::REG_MOTION_LOW:  rd_val = cfg_reg.motion_low;
            default:                  rd_val = 16'd0;
        endcase
    end

    assign prdata = {16'd0, rd_val};

endmodule

### design/spm_mag.sv
// ----------------------------------------------------------------------------
// spm_mag
// iterative magnitude unit: sum of squares then bit-pair square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_mag
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  spm_pkg::in_t       sample,
    output logic               done,
    output logic [15:0]        mag
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_SQR  = 2'd1;
    localparam logic [1:0] M_ROOT = 2'd2;

    localparam logic [3:0] SQR_LAST  = 4'd2;
    localparam logic [3:0] ROOT_LAST = 4'd15;

    logic [1:0]         phase_reg;
    logic [3:0]         cnt_reg;
    logic               done_reg;
    logic signed [15:0] ax_reg [0:2];
    logic [31:0]        acc_reg;
    logic [16:0]        rem_reg;
    logic [15:0]        root_reg;

    logic signed [31:0] prod;
    logic [31:0]        acc_sum;
    logic [18:0]        rem_sh;
    logic [18:0]        trial;
    logic               ge;

    // shared squarer, one axis a cycle
    assign prod    = ax_reg[0] * ax_reg[0];
    assign acc_sum = acc_reg + $unsigned(prod);

    // one root bit per step
    assign rem_sh = {rem_reg, acc_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= M_IDLE;
            cnt_reg   <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= M_SQR;
                        cnt_reg   <= 4'd0;
                    end
                end
                M_SQR:
                begin
                    if (cnt_reg == SQR_LAST)
                    begin
                        phase_reg <= M_ROOT;
                        cnt_reg   <= 4'd0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                M_ROOT:
                begin
                    if (cnt_reg == ROOT_LAST)
                    begin
                        phase_reg <= M_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default:
                begin
                    phase_reg <= M_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    ax_reg[0] <= sample.accel_x;
                    ax_reg[1] <= sample.accel_y;
                    ax_reg[2] <= sample.accel_z;
                    acc_reg   <= 32'd0;
                end
            end
            M_SQR:
            begin
                ax_reg[0] <= ax_reg[1];
                ax_reg[1] <= ax_reg[2];
                acc_reg   <= acc_sum;
                rem_reg   <= 17'd0;
                root_reg  <= 16'd0;
            end
            M_ROOT:
            begin
                acc_reg  <= {acc_reg[29:0], 2'b00};
                rem_reg  <= ge ? 17'(rem_sh - trial) : rem_sh[16:0];
                root_reg <= {root_reg[14:0], ge};
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign mag  = root_reg;

endmodule
